/* rtl/core/lzse_pkg.sv */
// shared types and constants of the lz sequence executor
package lzse_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_TOKEN   = 2'd1,
    OP_LITERAL = 2'd2,
    OP_BAD     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_OFFSET  = 2'd2,
    ST_ORDER   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_RD,
    S_COPY,
    S_EMIT
  } state_e;

  localparam int unsigned LenLongCode = 7;
  localparam int unsigned MatchMin    = 4;

endpackage

/* rtl/core/lzse_ram.sv */
// generic single-port-write one-read ram with registered read
module lzse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/core/lz_sequence_executor.sv */
// lz77 sequence executor: tokens, literals and byte-wise match copy
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata: operation,block_size,token_code,
//          |     |                  |        extra_length,match_offset,literal_value
//          |     |                  | tlast: final_token
//  m_axis  | out | tvalid/tready    | tdata: data_bytes,byte_count,write_position,
//          |     |                  |        status ; tuser: block_done ; tlast: run_last
// start, literal and error items pass through a response state to the output handoff.
// a match copies its bytes one at a time through the history ram (read, then write),
// and emits a result word when it is full or when the match ends.
// the ram read port loop sets the rate; overlapping copies see bytes just written.
// reset clears control state only; history is undefined until written.
// the input is not ready while an item is being worked or a result is waiting.
module lz_sequence_executor
  import lzse_pkg::*;
#(
  parameter int unsigned MAX_BLOCK        = 65536,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], block_size[18:2], token_code[22:19], extra_length[30:23],
  // match_offset[46:31], literal_value[54:47], zero fill [55]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // final_token
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_bytes[63:0], byte_count[67:64], write_position[84:68], status[86:85],
  // zero fill [87]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,   // block_done
  output logic        m_axis_tlast    // run_last
);
  localparam int unsigned AW = $clog2(MAX_BLOCK);
  localparam int unsigned BW = $clog2(BYTES_PER_RESULT + 1);

  logic [1:0]  in_op;
  logic [16:0] in_bsize;
  logic [3:0]  in_code;
  logic [7:0]  in_extra;
  logic [15:0] in_offset;
  logic [7:0]  in_lit;
  assign in_op     = s_axis_tdata[1:0];
  assign in_bsize  = s_axis_tdata[18:2];
  assign in_code   = s_axis_tdata[22:19];
  assign in_extra  = s_axis_tdata[30:23];
  assign in_offset = s_axis_tdata[46:31];
  assign in_lit    = s_axis_tdata[54:47];

  state_e state_q, state_d;
  logic [16:0] pos_q, pos_d, target_q, target_d;
  logic [8:0]  pend_q, pend_d;
  logic        err_q, err_d, fin_q, fin_d;
  logic [8:0]  remain_q, remain_d;       // bytes still to copy
  logic [15:0] off_q, off_d;
  logic [63:0] data_q, data_d;
  logic [BW-1:0] cnt_q, cnt_d;
  logic [16:0] first_q, first_d;
  logic [1:0]  stat_q, stat_d;
  logic        last_q, last_d, done_q, done_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  lzse_ram #(.Width(8), .Depth(MAX_BLOCK)) u_hist (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic        in_fire;
  logic [2:0]  low3;
  logic [8:0]  tok_len;
  logic [17:0] end_pos;
  logic [16:0] src_pos;
  logic        in_range;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign low3     = in_code[2:0];
  assign tok_len  = (in_code[3] ? 9'(low3) + 9'd1 : 9'(low3) + 9'(MatchMin))
                  + ((low3 == 3'(LenLongCode)) ? 9'(in_extra) : 9'd0);
  assign end_pos  = 18'(pos_q) + 18'(tok_len);
  assign src_pos  = pos_q - 17'(off_q);
  assign in_range = (32'(pos_q) < MAX_BLOCK) && (32'(src_pos) < MAX_BLOCK);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) begin
        if (in_op == OP_TOKEN && !err_q && pend_q == 9'd0 && !fin_q
            && !in_code[3] && end_pos <= 18'(target_q)
            && in_offset != 16'd0 && 17'(in_offset) <= pos_q)
          state_d = S_RD;
        else
          state_d = S_RESP;
      end
      S_RESP:  if (m_axis_tready) state_d = S_IDLE;
      S_RD:    state_d = S_COPY;
      S_COPY:  if (remain_q == 9'd1 || 32'(cnt_q) + 1 == BYTES_PER_RESULT)
                 state_d = S_EMIT;
               else
                 state_d = S_RD;
      S_EMIT:  if (m_axis_tready) state_d = last_q ? S_IDLE : S_RD;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_d = pos_q; target_d = target_q; pend_d = pend_q; err_d = err_q; fin_d = fin_q;
    remain_d = remain_q; off_d = off_q; data_d = data_q; cnt_d = cnt_q;
    first_d = first_q; stat_d = stat_q; last_d = last_q; done_d = done_q;
    we = 1'b0; waddr = AW'(pos_q); wdata = rdata; raddr = AW'(src_pos);
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_RESP) || (state_q == S_EMIT);
    case (state_q)
      S_IDLE: if (in_fire) begin
        data_d = '0; cnt_d = '0; first_d = pos_q; stat_d = ST_OK;
        last_d = 1'b1; done_d = 1'b0;
        if (in_op == OP_START) begin
          pos_d = '0; pend_d = '0; fin_d = 1'b0; first_d = '0;
          if (32'(in_bsize) > MAX_BLOCK) begin
            target_d = '0; err_d = 1'b1; stat_d = ST_OVERRUN;
          end else begin
            target_d = in_bsize; err_d = 1'b0;
          end
        end else if (err_q || in_op == OP_BAD) begin
          err_d = 1'b1; stat_d = ST_ORDER;
        end else if (in_op == OP_LITERAL) begin
          if (pend_q == 9'd0 || 32'(pos_q) >= MAX_BLOCK) begin
            err_d = 1'b1; stat_d = ST_ORDER;
          end else begin
            we = 1'b1; wdata = in_lit;
            data_d = 64'(in_lit); cnt_d = BW'(1);
            pos_d = pos_q + 17'd1; pend_d = pend_q - 9'd1;
            done_d = fin_q && pend_q == 9'd1 && (pos_q + 17'd1) == target_q;
          end
        end else if (pend_q != 9'd0 || fin_q) begin
          err_d = 1'b1; stat_d = ST_ORDER;
        end else if (end_pos > 18'(target_q)) begin
          err_d = 1'b1; stat_d = ST_OVERRUN;
        end else if (in_code[3]) begin
          pend_d = tok_len; fin_d = s_axis_tlast;
        end else if (in_offset == 16'd0 || 17'(in_offset) > pos_q) begin
          err_d = 1'b1; stat_d = ST_OFFSET;
        end else begin
          fin_d = s_axis_tlast; off_d = in_offset; remain_d = tok_len;
          last_d = 1'b0;
        end
      end
      S_COPY: begin
        we = in_range; wdata = rdata;
        data_d = data_q | (64'(in_range ? rdata : 8'd0) << {cnt_q, 3'b000});
        cnt_d = cnt_q + BW'(1);
        pos_d = pos_q + 17'd1;
        remain_d = remain_q - 9'd1;
        if (remain_q == 9'd1) begin
          last_d = 1'b1;
          done_d = fin_q && (pos_q + 17'd1) == target_q;
        end
      end
      S_EMIT: if (m_axis_tready) begin
        data_d = '0; cnt_d = '0; first_d = pos_q;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {1'b0, stat_q, first_q, 4'(cnt_q), data_q};
  assign m_axis_tlast = last_q;
  assign m_axis_tuser = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pos_q <= '0; target_q <= '0; pend_q <= '0;
      err_q <= 1'b0; fin_q <= 1'b0; remain_q <= '0; cnt_q <= '0;
      last_q <= 1'b0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; pos_q <= pos_d; target_q <= target_d; pend_q <= pend_d;
      err_q <= err_d; fin_q <= fin_d; remain_q <= remain_d; cnt_q <= cnt_d;
      last_q <= last_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d; data_q <= data_d; first_q <= first_d; stat_q <= stat_d;
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= target_q || err_q) else $error("position past target");
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> cnt_q != '0) else $error("empty copy result");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("done without last");
  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stat_q != ST_OK |-> cnt_q == '0 && m_axis_tlast)
    else $error("error result carries bytes");
endmodule

/* tb/tb_top.sv */
// testbench of the lz sequence executor: scoreboard, stimulus and checks
module tb_top;
  import lzse_pkg::*;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic [16:0] pos;
    logic [1:0]  status;
    logic        last;
    logic        done;
  } outword_t;

  // shadow of the executor state and queue of expected output words
  class lz_scoreboard;
    logic [7:0]  hist [int];
    logic [16:0] wpos;
    logic [16:0] tsize;
    logic [8:0]  lits_left;
    logic        err;
    logic        fin_seen;
    outword_t    pending_q[$];
    int          errors;

    function void init();
      wpos = 0; tsize = 0; lits_left = 0; err = 0; fin_seen = 0;
      errors = 0;
      pending_q.delete();
      hist.delete();
    endfunction

    function void push(logic [63:0] d, logic [3:0] n, logic [16:0] p, status_e s,
                       logic l, logic dn);
      outword_t w;
      w.data = d; w.count = n; w.pos = p; w.status = s; w.last = l; w.done = dn;
      pending_q.push_back(w);
    endfunction

    function void flag(status_e s);
      err = 1;
      push(0, 0, wpos, s, 1, 0);
    endfunction

    function bit complete();
      return fin_seen && lits_left == 0 && wpos == tsize;
    endfunction

    function void note_input(op_e op, logic [16:0] bsize, logic [3:0] code,
                             logic [7:0] extra, logic [15:0] offs, logic [7:0] lit,
                             logic fin);
      int unsigned len, src, dst, i, n, first;
      logic [63:0] d;
      if (op == OP_START) begin
        wpos = 0; lits_left = 0; fin_seen = 0; err = 0;
        if (bsize > 17'd65536) begin
          tsize = 0;
          flag(ST_OVERRUN);
        end else begin
          tsize = bsize;
          push(0, 0, 0, ST_OK, 1, 0);
        end
        return;
      end
      if (err || op == OP_BAD) begin
        flag(ST_ORDER);
        return;
      end
      if (op == OP_LITERAL) begin
        if (lits_left == 0 || wpos >= 17'd65536) begin
          flag(ST_ORDER);
          return;
        end
        hist[wpos] = lit;
        first = wpos;
        wpos = wpos + 17'd1;
        lits_left = lits_left - 9'd1;
        push({56'd0, lit}, 1, 17'(first), ST_OK, 1, complete());
        return;
      end
      if (lits_left != 0 || fin_seen) begin
        flag(ST_ORDER);
        return;
      end
      len = code[3] ? code[2:0] + 1 : code[2:0] + MatchMin;
      if (code[2:0] == LenLongCode) len += extra;
      if (wpos + len > tsize) begin
        flag(ST_OVERRUN);
        return;
      end
      if (code[3]) begin
        lits_left = 9'(len);
        fin_seen = fin;
        push(0, 0, wpos, ST_OK, 1, 0);
        return;
      end
      if (offs == 0 || offs > wpos) begin
        flag(ST_OFFSET);
        return;
      end
      fin_seen = fin;
      i = 0;
      first = wpos;
      while (i < len) begin
        d = 0; n = 0;
        dst = first + i;
        while (n < 8 && i < len) begin
          dst = first + i;
          src = dst - offs;
          hist[dst] = hist[src];
          d[8*n +: 8] = hist[src];
          n++; i++;
        end
        wpos = 17'(first + i);
        push(d, 4'(n), 17'(first + i - n), ST_OK, i == len, i == len && complete());
      end
    endfunction

    function void check(outword_t got);
      outword_t w;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected output word: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (got.data !== w.data) begin
        $display("%0t data_bytes: expected %h, actual %h", $time, w.data, got.data);
        errors++;
      end
      if (got.count !== w.count) begin
        $display("%0t byte_count: expected %0d, actual %0d", $time, w.count, got.count);
        errors++;
      end
      if (got.pos !== w.pos) begin
        $display("%0t write_position: expected %0d, actual %0d", $time, w.pos, got.pos);
        errors++;
      end
      if (got.status !== w.status) begin
        $display("%0t status: expected %0d, actual %0d", $time, w.status, got.status);
        errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t run_last: expected %b, actual %b", $time, w.last, got.last);
        errors++;
      end
      if (got.done !== w.done) begin
        $display("%0t block_done: expected %b, actual %b", $time, w.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser, m_axis_tlast;
  logic [87:0] m_axis_tdata;

  lz_sequence_executor dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  lz_scoreboard sb;
  int  stall_cnt;
  bit  finished;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: random stalls after each accepted word
  initial begin
    m_axis_tready = 0;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tready && m_axis_tvalid) begin
        outword_t g;
        g.data = m_axis_tdata[63:0];
        g.count = m_axis_tdata[67:64];
        g.pos = m_axis_tdata[84:68];
        g.status = m_axis_tdata[86:85];
        g.last = m_axis_tlast;
        g.done = m_axis_tuser;
        sb.check(g);
        stall_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= 4000 && !finished) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // valid stays up after a transfer until the next item or an idle gap replaces it
  task automatic send(op_e op, logic [16:0] bsize, logic [3:0] code, logic [7:0] extra,
                      logic [15:0] offs, logic [7:0] lit, logic fin);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, lit, offs, extra, code, bsize, op};
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, bsize, code, extra, offs, lit, fin);
  endtask

  task automatic start_blk(logic [16:0] bsize);
    send(OP_START, bsize, 4'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
         1'($urandom));
  endtask

  // literal run of n bytes (1..263) with random content
  task automatic lit_run(int n, logic fin);
    logic [3:0] code;
    logic [7:0] extra;
    if (n >= 8) begin code = 4'hF; extra = 8'(n - 8); end
    else begin code = {1'b1, 3'(n - 1)}; extra = 8'($urandom); end
    send(OP_TOKEN, 17'($urandom), code, extra, 16'($urandom), 8'($urandom), fin);
    repeat (n) send(OP_LITERAL, 17'($urandom), 4'($urandom), 8'($urandom),
                    16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic match(int n, logic [15:0] offs, logic fin);
    logic [3:0] code;
    logic [7:0] extra;
    if (n >= 11) begin code = 4'h7; extra = 8'(n - 11); end
    else begin code = {1'b0, 3'(n - 4)}; extra = 8'($urandom); end
    send(OP_TOKEN, 17'($urandom), code, extra, offs, 8'($urandom), fin);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // one well-formed block with random content, sometimes cut short
  task automatic random_block();
    int total, produced, n, left;
    total = $urandom_range(20, 80);
    start_blk(17'(total));
    produced = 0;
    while (produced < total) begin
      left = total - produced;
      if (produced == 0 || $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, (left < 263) ? left : 263);
        if ($urandom_range(0, 3) != 0 && n > 12) n = $urandom_range(1, 12);
        lit_run(n, produced + n == total);
      end else if (left >= 4) begin
        n = $urandom_range(4, (left < 266) ? left : 266);
        if ($urandom_range(0, 3) != 0 && n > 20) n = $urandom_range(4, 20);
        match(n, 16'((produced > 1 && $urandom_range(0, 1)) ?
              $urandom_range(1, produced) : $urandom_range(1, 3) % produced + 1),
              produced + n == total);
      end else begin
        lit_run(left, 1);
        n = left;
      end
      produced += n;
      if ($urandom_range(0, 15) == 0) begin
        // noise: a broken item
        send(op_e'($urandom_range(1, 3)), 17'($urandom), 4'($urandom), 8'($urandom),
             16'($urandom), 8'($urandom), 1'($urandom));
        break;
      end
    end
  endtask

  initial begin
    int k;
    sb = new();
    sb.init();
    finished = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed part
    send(OP_TOKEN, 0, 4'h8, 0, 0, 0, 0);                 // token before any start
    start_blk(17'h1FFFF);                                // oversize block
    send(OP_LITERAL, 0, 0, 0, 0, 8'hFF, 0);              // under latched error
    start_blk(17'd65536);
    send(OP_LITERAL, 0, 0, 0, 0, 8'h00, 0);              // literal with none pending
    start_blk(300);
    lit_run(1, 0);
    match(4, 16'd2, 0);                                  // offset beyond position
    start_blk(300);
    lit_run(3, 0);
    match(266, 16'd1, 0);                                // longest overlapping match
    match(4, 16'hFFFF, 0);
    start_blk(40);
    lit_run(8, 0);
    send(OP_TOKEN, 0, 4'h0, 0, 16'd0, 0, 0);             // zero offset
    start_blk(40);
    lit_run(2, 0);
    send(OP_TOKEN, 0, 4'h9, 0, 0, 0, 0);                 // token that leaves literals pending
    start_blk(20);
    lit_run(8, 0);
    match(12, 16'd8, 1);                                 // exact end, done
    send(OP_TOKEN, 0, 4'h8, 0, 0, 0, 0);                 // token after final
    start_blk(20);
    lit_run(5, 1);                                       // short final block
    send(OP_BAD, 0, 0, 0, 0, 0, 0);
    start_blk(5);
    send(OP_TOKEN, 0, 4'hF, 8'hFF, 0, 0, 0);             // size overrun
    drain();

    // random part
    k = 0;
    while (k < 6) begin
      random_block();
      k++;
      if (k == 3) drain();
    end
    drain();
    repeat (300) @(posedge clk_i);
    finished = 1;
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
